// File: sv/clls_pkg.sv
// Shared types and constants for the console log line sanitizer.
package clls_pkg;

  // Most result items a single input byte can cause.
  localparam int MaxItems = 5;
  localparam int CountW   = $clog2(MaxItems + 1);

  // Configuration register indexes.
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgSanitize  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTimestamp = 1'd1;

  // Line state codes.
  localparam logic [1:0] LsInit = 2'd0;
  localparam logic [1:0] LsData = 2'd1;
  localparam logic [1:0] LsCr   = 2'd2;
  localparam logic [1:0] LsLf   = 2'd3;

  // Character constants.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChGrave = 8'h60;
  localparam logic [7:0] ChQuery = 8'h3F;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [6:0] ChSpace = 7'h20;
  localparam logic [6:0] ChDel   = 7'h7F;

  // The result items of one input byte, oldest in slot 0.
  typedef struct packed {
    logic [MaxItems-1:0][7:0] bytes;
    logic [MaxItems-1:0]      ts;
    logic [CountW-1:0]        count;
  } clls_list_t;

endpackage

// File: sv/console_log_line_sanitizer.sv
// Top level of the console log line sanitizer.
// Throughput: one input item per cycle when each causes at most one result item and the output is not
// stalled; an item that causes more result items (up to five) holds off the next one until its last
// result item moves into the output register.
// Reset: asynchronous, active low; clears the line state to init, both options off, pipeline empty.
module console_log_line_sanitizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [clls_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic                         cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   in_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   out_byte_o,
  output logic                         timestamp_here_o,
  output logic                         last_o
);

  clls_pkg::clls_list_t list;
  logic                 accept;

  assign accept = in_valid_i && in_ready_o;

  // Decode of the incoming byte against the line state.
  clls_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .list_o      (list)
  );

  // Emission of the decoded items, one per cycle while the output is not stalled.
  clls_emitter u_emitter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .list_i           (list),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .timestamp_here_o (timestamp_here_o),
    .last_o           (last_o)
  );

endmodule

// File: sv/clls_decoder.sv
// Line state register, configuration registers and byte-to-item-list decode.
module clls_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [clls_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic                           cfg_data_i,
  input  logic                           accept_i,
  input  logic [7:0]                     in_byte_i,
  output clls_pkg::clls_list_t           list_o
);

  logic       sanitize_q;
  logic       timestamp_q;
  logic [1:0] line_state_q;
  logic [1:0] line_state_d;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sanitize_q  <= 1'b0;
      timestamp_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        clls_pkg::CfgSanitize:  sanitize_q  <= cfg_data_i;
        clls_pkg::CfgTimestamp: timestamp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Line state advances only when an item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_state_q <= clls_pkg::LsInit;
    end else if (accept_i) begin
      line_state_q <= line_state_d;
    end
  end

  // Build the list of result items for the incoming byte.
  always_comb begin
    clls_pkg::clls_list_t lst;
    logic [6:0] c;
    logic [7:0] pre;
    lst = '0;
    line_state_d = line_state_q;
    c   = in_byte_i[6:0];
    pre = in_byte_i[7] ? clls_pkg::ChTilde : clls_pkg::ChCaret;

    if (!sanitize_q && !timestamp_q) begin
      lst.bytes[lst.count] = in_byte_i;
      lst.count = lst.count + 1'b1;
    end else if (in_byte_i == clls_pkg::ChCr) begin
      if (line_state_q == clls_pkg::LsData) begin
        line_state_d = clls_pkg::LsCr;
      end else if (line_state_q == clls_pkg::LsInit) begin
        if (timestamp_q) begin
          lst.ts[lst.count] = 1'b1;
          lst.count = lst.count + 1'b1;
        end
        line_state_d = clls_pkg::LsCr;
      end
    end else if (in_byte_i == clls_pkg::ChLf) begin
      if (timestamp_q && (line_state_q == clls_pkg::LsInit ||
                          line_state_q == clls_pkg::LsLf)) begin
        lst.ts[lst.count] = 1'b1;
        lst.count = lst.count + 1'b1;
      end
      lst.bytes[lst.count] = clls_pkg::ChCr;
      lst.count = lst.count + 1'b1;
      lst.bytes[lst.count] = clls_pkg::ChLf;
      lst.count = lst.count + 1'b1;
      line_state_d = clls_pkg::LsLf;
    end else if (in_byte_i == clls_pkg::ChNul && (line_state_q == clls_pkg::LsCr ||
                                                  line_state_q == clls_pkg::LsLf)) begin
      // A NUL straight after a line end is dropped.
    end else begin
      if (line_state_q == clls_pkg::LsCr) begin
        lst.bytes[lst.count] = clls_pkg::ChCr;
        lst.count = lst.count + 1'b1;
        lst.bytes[lst.count] = clls_pkg::ChLf;
        lst.count = lst.count + 1'b1;
      end
      if (timestamp_q && line_state_q != clls_pkg::LsData) begin
        lst.ts[lst.count] = 1'b1;
        lst.count = lst.count + 1'b1;
      end
      line_state_d = clls_pkg::LsData;

      if (sanitize_q) begin
        if (c < clls_pkg::ChSpace) begin
          lst.bytes[lst.count] = pre;
          lst.count = lst.count + 1'b1;
          lst.bytes[lst.count] = {1'b0, c} + clls_pkg::ChAt;
          lst.count = lst.count + 1'b1;
        end else if (c == clls_pkg::ChDel) begin
          lst.bytes[lst.count] = pre;
          lst.count = lst.count + 1'b1;
          lst.bytes[lst.count] = clls_pkg::ChQuery;
          lst.count = lst.count + 1'b1;
        end else begin
          if (in_byte_i[7]) begin
            lst.bytes[lst.count] = clls_pkg::ChGrave;
            lst.count = lst.count + 1'b1;
          end
          lst.bytes[lst.count] = {1'b0, c};
          lst.count = lst.count + 1'b1;
        end
      end else begin
        lst.bytes[lst.count] = in_byte_i;
        lst.count = lst.count + 1'b1;
      end
    end
    list_o = lst;
  end

endmodule

// File: sv/clls_emitter.sv
// Item list register and output register that hand out one item per cycle while the output is not stalled.
module clls_emitter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  clls_pkg::clls_list_t  list_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  timestamp_here_o,
  output logic                  last_o
);

  logic [clls_pkg::MaxItems-1:0][7:0] bytes_q;
  logic [clls_pkg::MaxItems-1:0]      ts_q;
  logic [clls_pkg::CountW-1:0]        cnt_q;
  logic                               out_valid_q;
  logic [7:0]                         out_byte_q;
  logic                               ts_out_q;
  logic                               last_q;
  logic                               adv;
  logic                               load;

  // The output register moves when it is empty or being taken.
  assign adv = !out_valid_q || out_ready_i;
  // A new item is taken once the list is drained, or drains this cycle.
  assign in_ready_o = (cnt_q == '0) || (cnt_q == 1'b1 && adv);
  assign load = in_valid_i && in_ready_o && (list_i.count != '0);

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= (cnt_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && cnt_q != '0) begin
      out_byte_q <= bytes_q[0];
      ts_out_q   <= ts_q[0];
      last_q     <= (cnt_q == 1'b1);
    end
  end

  // List register: loaded from the decoder, shifted down as items leave.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= list_i.count;
    end else if (adv && cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= list_i.bytes;
      ts_q    <= list_i.ts;
    end else if (adv && cnt_q != '0) begin
      bytes_q <= bytes_q >> 8;
      ts_q    <= ts_q >> 1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign timestamp_here_o = ts_out_q;
  assign last_o           = last_q;

endmodule

// File: sv/clls_checker.sv
// Port-level checks for the console log line sanitizer, bound to the top level.
module clls_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       timestamp_here_i,
  input logic       last_i
);

  // A stalled result item holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(timestamp_here_i) && $stable(last_i))
    else $error("stalled result item changed");

  // A timestamp marker carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && timestamp_here_i |-> out_byte_i == 8'h00)
    else $error("marker item with non-zero byte");

  // Items of one input byte leave without a gap until the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i)
    else $error("gap before the last item of a byte");

  // A marker is never followed directly by another marker within one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && timestamp_here_i && !last_i |=> !timestamp_here_i)
    else $error("two markers from one byte");

endmodule

bind console_log_line_sanitizer clls_checker u_clls_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .out_byte_i       (out_byte_o),
  .timestamp_here_i (timestamp_here_o),
  .last_i           (last_o)
);
